// File: src/assert_macros.svh
// assertion macros shared by the morse encoder rtl
// every macro samples on clk_i and is disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every sampled edge
`define MCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next one
`define MCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/mce_pkg.sv
// types, constants and the character code table for the morse encoder
// no dependencies
package mce_pkg;

  typedef enum logic [1:0] {
    KIND_DOT  = 2'd0,
    KIND_DASH = 2'd1,
    KIND_GAP  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_TONE_FREQ = 2'd0,
    CFG_DOT_MS    = 2'd1,
    CFG_DASH_MS   = 2'd2,
    CFG_GAP_MS    = 2'd3
  } cfg_idx_e;

  localparam logic [14:0] ToneFreqRst = 15'd1300;
  localparam logic [15:0] DotMsRst    = 16'd200;
  localparam logic [15:0] DashMsRst   = 16'd500;
  localparam logic [15:0] GapMsRst    = 16'd1000;

  typedef struct packed {
    logic [7:0] character;
  } char_t;

  typedef struct packed {
    kind_e       kind;
    logic [14:0] tone_hz;
    logic [15:0] duration_ms;
    logic        last;
  } elem_t;

  // pattern is left aligned: bit 5 is the first element, 1 means dash
  typedef struct packed {
    logic [2:0] len;
    logic [5:0] pattern;
  } code_t;

  typedef struct packed {
    logic       valid;
    code_t      code;
  } q_rd_t;

  typedef struct packed {
    logic [14:0] tone_freq;
    logic [15:0] dot_ms;
    logic [15:0] dash_ms;
    logic [15:0] gap_ms;
  } cfg_t;

  function automatic code_t mk_code(input logic [2:0] len, input logic [5:0] pat);
    code_t c;
    c.len     = len;
    c.pattern = pat;
    return c;
  endfunction

  function automatic code_t code_lookup(input logic [7:0] ch);
    logic [7:0] up;
    code_t      c;
    up = ch;
    if (ch >= "a" && ch <= "z") begin
      up = ch - 8'd32;
    end
    unique case (up)
      "A": c = mk_code(3'd2, 6'b010000);
      "B": c = mk_code(3'd4, 6'b100000);
      "C": c = mk_code(3'd4, 6'b101000);
      "D": c = mk_code(3'd3, 6'b100000);
      "E": c = mk_code(3'd1, 6'b000000);
      "F": c = mk_code(3'd4, 6'b001000);
      "G": c = mk_code(3'd3, 6'b110000);
      "H": c = mk_code(3'd4, 6'b000000);
      "I": c = mk_code(3'd2, 6'b000000);
      "J": c = mk_code(3'd4, 6'b011100);
      "K": c = mk_code(3'd3, 6'b101000);
      "L": c = mk_code(3'd4, 6'b010000);
      "M": c = mk_code(3'd2, 6'b110000);
      "N": c = mk_code(3'd2, 6'b100000);
      "O": c = mk_code(3'd3, 6'b111000);
      "P": c = mk_code(3'd4, 6'b011000);
      "Q": c = mk_code(3'd4, 6'b110100);
      "R": c = mk_code(3'd3, 6'b010000);
      "S": c = mk_code(3'd3, 6'b000000);
      "T": c = mk_code(3'd1, 6'b100000);
      "U": c = mk_code(3'd3, 6'b001000);
      "V": c = mk_code(3'd4, 6'b000100);
      "W": c = mk_code(3'd3, 6'b011000);
      "X": c = mk_code(3'd4, 6'b100100);
      "Y": c = mk_code(3'd4, 6'b101100);
      "Z": c = mk_code(3'd4, 6'b110000);
      "0": c = mk_code(3'd5, 6'b111110);
      "1": c = mk_code(3'd5, 6'b011110);
      "2": c = mk_code(3'd5, 6'b001110);
      "3": c = mk_code(3'd5, 6'b000110);
      "4": c = mk_code(3'd5, 6'b000010);
      "5": c = mk_code(3'd5, 6'b000000);
      "6": c = mk_code(3'd5, 6'b100000);
      "7": c = mk_code(3'd5, 6'b110000);
      "8": c = mk_code(3'd5, 6'b111000);
      "9": c = mk_code(3'd5, 6'b111100);
      "&": c = mk_code(3'd5, 6'b010000);
      "@": c = mk_code(3'd6, 6'b011010);
      ".": c = mk_code(3'd6, 6'b010101);
      ",": c = mk_code(3'd6, 6'b110011);
      "$": c = mk_code(3'd6, 6'b001100);
      default: c = mk_code(3'd0, 6'b000000);
    endcase
    return c;
  endfunction

endpackage

// File: src/mce_chan_if.sv
// valid/ready channel carrying one payload item per transfer
// payload type is set per instance, usually a struct from mce_pkg
interface mce_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/mce_front.sv
// front end: takes characters and classifies them into element codes
// uses mce_pkg and mce_chan_if
module mce_front (
  mce_chan_if.sink          char_i,
  output logic              push_valid_o,
  output mce_pkg::code_t    push_code_o,
  input  logic              push_ready_i
);
  import mce_pkg::*;

  assign push_valid_o = char_i.valid;
  assign push_code_o  = code_lookup(char_i.data.character);
  assign char_i.ready = push_ready_i;

endmodule

// File: src/mce_fifo.sv
// two entry queue of element codes between front and back
// uses mce_pkg
module mce_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  mce_pkg::code_t push_code_i,
  output logic           push_ready_o,
  output mce_pkg::q_rd_t rd_o,
  input  logic           pop_i
);
  import mce_pkg::*;

  code_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && (cnt_q != 2'd0);

  assign rd_o.valid = (cnt_q != 2'd0);
  assign rd_o.code  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_code_i;
    end
  end

endmodule

// File: src/mce_back.sv
// back end: walks one element code and emits dots, dashes and the gap
// uses mce_pkg and mce_chan_if
module mce_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mce_pkg::q_rd_t rd_i,
  output logic           pop_o,
  input  mce_pkg::cfg_t  cfg_i,
  mce_chan_if.source     elem_o,
  output logic           busy_o
);
  import mce_pkg::*;

  logic       busy_q, busy_d;
  logic [5:0] pat_q, pat_d;
  logic [2:0] rem_q, rem_d;
  logic       out_valid_q, out_valid_d;
  elem_t      out_q, out_d;
  logic       adv;

  // output register moves when empty or being drained
  assign adv = !out_valid_q || elem_o.ready;
  // gap cycle frees the sequencer so the next code loads alongside it
  assign pop_o = rd_i.valid && (!busy_q || (adv && rem_q == 3'd0));

  always_comb begin
    busy_d      = busy_q;
    pat_d       = pat_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (adv) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        if (rem_q != 3'd0) begin
          out_d.kind        = pat_q[5] ? KIND_DASH : KIND_DOT;
          out_d.tone_hz     = cfg_i.tone_freq;
          out_d.duration_ms = pat_q[5] ? cfg_i.dash_ms : cfg_i.dot_ms;
          out_d.last        = 1'b0;
          pat_d             = {pat_q[4:0], 1'b0};
          rem_d             = rem_q - 3'd1;
        end else begin
          out_d.kind        = KIND_GAP;
          out_d.tone_hz     = '0;
          out_d.duration_ms = cfg_i.gap_ms;
          out_d.last        = 1'b1;
          busy_d            = 1'b0;
        end
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      pat_d  = rd_i.code.pattern;
      rem_d  = rd_i.code.len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rem_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
    out_q <= out_d;
  end

  assign elem_o.valid = out_valid_q;
  assign elem_o.data  = out_q;
  assign busy_o       = busy_q;

endmodule

// File: src/morse_character_encoder_top.sv
// International Morse character encoder.
// char_i takes one ASCII character per transfer; elem_o gives that character's
// elements in order, one per transfer: dots and dashes with the configured tone
// and duration, then one silent gap with last set. Letters ignore case; digits
// and the signs & @ . , $ are coded, anything else yields only the gap.
// The write port (cfg_we_i, cfg_idx_i, cfg_wdata_i) sets tone, dot, dash and
// gap lengths; change them only while no character is in flight.
// From idle, a transferred character is written into the code queue, loaded
// into the back-end sequencer and its first element registered for output.
// A character gives n+1 elements, n the number of dots and dashes (0 to 6),
// so 1 to 7; the back-end sequencer emits one element per cycle while the
// receiver takes them, loading the next code as it emits the gap. A two-entry
// code queue lets characters keep coming while the back end works. If the
// receiver stalls, the output register holds its item and the queue fills
// before char_i.ready drops. Reset returns the registers to 1300 Hz, 200, 500
// and 1000 ms and empties the queue and the output register.
`include "assert_macros.svh"

module morse_character_encoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  mce_chan_if.sink            char_i,
  mce_chan_if.source          elem_o,
  input  logic                cfg_we_i,
  input  mce_pkg::cfg_idx_e   cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i
);
  import mce_pkg::*;

  cfg_t  cfg_q;
  logic  push_valid, push_ready, pop, busy;
  code_t push_code;
  q_rd_t rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tone_freq <= ToneFreqRst;
      cfg_q.dot_ms    <= DotMsRst;
      cfg_q.dash_ms   <= DashMsRst;
      cfg_q.gap_ms    <= GapMsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TONE_FREQ: cfg_q.tone_freq <= cfg_wdata_i[14:0];
        CFG_DOT_MS:    cfg_q.dot_ms    <= cfg_wdata_i;
        CFG_DASH_MS:   cfg_q.dash_ms   <= cfg_wdata_i;
        CFG_GAP_MS:    cfg_q.gap_ms    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mce_front u_front (
    .char_i       (char_i),
    .push_valid_o (push_valid),
    .push_code_o  (push_code),
    .push_ready_i (push_ready)
  );

  mce_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_code_i  (push_code),
    .push_ready_o (push_ready),
    .rd_o         (rd),
    .pop_i        (pop)
  );

  mce_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (rd),
    .pop_o  (pop),
    .cfg_i  (cfg_q),
    .elem_o (elem_o),
    .busy_o (busy)
  );

  `MCE_ASSERT(a_gap_is_last, elem_o.valid |-> ((elem_o.data.kind == KIND_GAP) == elem_o.data.last), "gap and last flag disagree")
  `MCE_ASSERT(a_gap_silent, (elem_o.valid && elem_o.data.last) |-> (elem_o.data.tone_hz == 15'd0), "gap carries a tone")
  `MCE_ASSERT_NEXT(a_char_held, char_i.valid && char_i.ready, rd.valid || busy, "accepted character lost")

endmodule

// File: dv/tb_morse_character_encoder_top.sv
// testbench for morse_character_encoder_top: random characters and register
// settings, every element checked against a predictor kept in this file
// needs mce_pkg, mce_chan_if and the encoder rtl
`timescale 1ns / 1ps

module tb_morse_character_encoder_top;
  import mce_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  cfg_idx_e   cfg_idx = CFG_TONE_FREQ;
  logic [15:0] cfg_wdata = '0;

  mce_chan_if #(.T(char_t)) char_if ();
  mce_chan_if #(.T(elem_t)) elem_if ();

  morse_character_encoder_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .char_i      (char_if),
    .elem_o      (elem_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // register copies used for prediction
  logic [14:0] tone_hz_cfg = ToneFreqRst;
  logic [15:0] dot_len_ms = DotMsRst;
  logic [15:0] dash_len_ms = DashMsRst;
  logic [15:0] gap_len_ms = GapMsRst;

  logic [7:0] pending_chars [$];
  elem_t      expected_elems [$];
  elem_t      expected_now;

  logic full_rate = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   mismatch_count = 0;
  int   chars_sent = 0;
  int   elems_checked = 0;
  int   config_sets = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_char();
    string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789&@.,$";
    int    r;
    r = $urandom_range(0, 9);
    if (r < 7) return alphabet[$urandom_range(0, alphabet.len() - 1)];
    if (r < 9) return 8'($urandom_range(0, 255));
    return " ";
  endfunction

  // dots and dashes of one character, empty when it has no code
  function automatic string morse_pattern(input logic [7:0] ch);
    logic [7:0] up;
    up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    case (up)
      "A": return ".-";     "B": return "-...";   "C": return "-.-.";
      "D": return "-..";    "E": return ".";      "F": return "..-.";
      "G": return "--.";    "H": return "....";   "I": return "..";
      "J": return ".---";   "K": return "-.-";    "L": return ".-..";
      "M": return "--";     "N": return "-.";     "O": return "---";
      "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
      "S": return "...";    "T": return "-";      "U": return "..-";
      "V": return "...-";   "W": return ".--";    "X": return "-..-";
      "Y": return "-.--";   "Z": return "--..";
      "0": return "-----";  "1": return ".----";  "2": return "..---";
      "3": return "...--";  "4": return "....-";  "5": return ".....";
      "6": return "-....";  "7": return "--...";  "8": return "---..";
      "9": return "----.";
      "&": return ".-...";  "@": return ".--.-."; ".": return ".-.-.-";
      ",": return "--..--"; "$": return "..--..";
      default: return "";
    endcase
  endfunction

  function automatic void queue_elements(input logic [7:0] ch);
    string pat;
    elem_t e;
    pat = morse_pattern(ch);
    for (int i = 0; i < pat.len(); i++) begin
      e.tone_hz = tone_hz_cfg;
      e.last    = 1'b0;
      if (pat[i] == "-") begin
        e.kind        = KIND_DASH;
        e.duration_ms = dash_len_ms;
      end else begin
        e.kind        = KIND_DOT;
        e.duration_ms = dot_len_ms;
      end
      expected_elems.push_back(e);
    end
    e.kind        = KIND_GAP;
    e.tone_hz     = '0;
    e.duration_ms = gap_len_ms;
    e.last        = 1'b1;
    expected_elems.push_back(e);
  endfunction

  // character driver
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      char_if.valid <= 1'b0;
      gap_left      <= 0;
    end else if (!(char_if.valid && !char_if.ready)) begin
      if (gap_left != 0) begin
        char_if.valid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (pending_chars.size() != 0) begin
        char_if.valid          <= 1'b1;
        char_if.data.character <= pending_chars.pop_front();
        gap_left               <= full_rate ? 0 : idle_len();
      end else begin
        char_if.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      elem_if.ready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      elem_if.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      elem_if.ready <= 1'b1;
      if (!full_rate && $urandom_range(0, 3) == 0) stall_left <= idle_len();
    end
  end

  // expected elements for every character transfer
  always @(posedge clk_i) begin
    if (rst_n && char_if.valid && char_if.ready) begin
      queue_elements(char_if.data.character);
      chars_sent++;
    end
  end

  // element checker
  always @(posedge clk_i) begin
    if (rst_n && elem_if.valid && elem_if.ready) begin
      elems_checked++;
      if (expected_elems.size() == 0) begin
        report_mismatch($sformatf("unexpected element kind %0d dur %0d",
                                  elem_if.data.kind, elem_if.data.duration_ms));
      end else begin
        expected_now = expected_elems.pop_front();
        if (elem_if.data.kind !== expected_now.kind)
          report_mismatch($sformatf("kind got %0d exp %0d",
                                    elem_if.data.kind, expected_now.kind));
        if (elem_if.data.tone_hz !== expected_now.tone_hz)
          report_mismatch($sformatf("tone_hz got %0d exp %0d",
                                    elem_if.data.tone_hz, expected_now.tone_hz));
        if (elem_if.data.duration_ms !== expected_now.duration_ms)
          report_mismatch($sformatf("duration_ms got %0d exp %0d",
                                    elem_if.data.duration_ms, expected_now.duration_ms));
        if (elem_if.data.last !== expected_now.last)
          report_mismatch($sformatf("last got %0d exp %0d",
                                    elem_if.data.last, expected_now.last));
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_TONE_FREQ: tone_hz_cfg = value[14:0];
      CFG_DOT_MS:    dot_len_ms = value;
      CFG_DASH_MS:   dash_len_ms = value;
      CFG_GAP_MS:    gap_len_ms = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] tone, input logic [15:0] dot,
                            input logic [15:0] dash, input logic [15:0] gap);
    write_reg(CFG_TONE_FREQ, tone);
    write_reg(CFG_DOT_MS, dot);
    write_reg(CFG_DASH_MS, dash);
    write_reg(CFG_GAP_MS, gap);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    config_sets++;
    @(negedge clk_i);
  endtask

  // block is idle once every queued character has produced all its elements
  task automatic wait_for_idle();
    int guard;
    guard = 0;
    while ((pending_chars.size() != 0 || char_if.valid || expected_elems.size() != 0)
           && guard < 50000) begin
      @(negedge clk_i);
      guard++;
    end
    if (expected_elems.size() != 0) begin
      report_mismatch($sformatf("%0d elements never arrived", expected_elems.size()));
      expected_elems.delete();
    end
    repeat (8) @(negedge clk_i);
  endtask

  task automatic run_phase(input int count, input logic fast);
    full_rate = fast;
    repeat (count) pending_chars.push_back(pick_char());
    wait_for_idle();
  endtask

  initial begin
    string directed_text;
    directed_text = "Az09q&@.,$ #E5T";
    rst_n         = 1'b0;
    char_if.valid = 1'b0;
    char_if.data  = '0;
    elem_if.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // reset settings: every coded sign, both cases, no-code and non-ascii bytes
    for (int i = 0; i < directed_text.len(); i++) pending_chars.push_back(directed_text[i]);
    pending_chars.push_back(8'h00);
    pending_chars.push_back(8'hFF);
    pending_chars.push_back(8'h80);
    pending_chars.push_back(8'h7F);
    wait_for_idle();

    // sound off and zero lengths, then everything at its maximum
    set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_phase(30, 1'b0);
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(30, 1'b1);

    for (int p = 0; p < 5; p++) begin
      set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      run_phase(40, p[0]);
    end

    $display("sent %0d characters over %0d register settings, checked %0d elements",
             chars_sent, config_sets + 1, elems_checked);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: morse_character_encoder_top.f
+incdir+src
src/mce_pkg.sv
src/mce_chan_if.sv
src/mce_front.sv
src/mce_fifo.sv
src/mce_back.sv
src/morse_character_encoder_top.sv
dv/tb_morse_character_encoder_top.sv
